// ===== rtl/core/correlated_gbm_euler_antithetic_core_defines.svh =====
// assertion macros for the correlated path core checker
// needs clk and rst_n in the scope where a macro is used
`ifndef CORRELATED_GBM_EULER_ANTITHETIC_CORE_DEFINES_SVH
`define CORRELATED_GBM_EULER_ANTITHETIC_CORE_DEFINES_SVH

// same-cycle implication
`define CGBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define CGBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/cgbm_pkg.sv =====
// shared types, codes and helpers for the correlated path core
// no dependencies
package cgbm_pkg;

    localparam int NUM_ASSETS_DEF = 4;
    localparam int MAX_STEPS_DEF  = 1024;
    localparam int ADDR_W         = 5;

    localparam logic [1:0] OP_LOAD_FACTOR = 2'd0;
    localparam logic [1:0] OP_LOAD_SPOT   = 2'd1;
    localparam logic [1:0] OP_START       = 2'd2;
    localparam logic [1:0] OP_STEP        = 2'd3;

    localparam logic [2:0] REG_DRIFT0    = 3'd0;
    localparam logic [2:0] REG_DRIFT1    = 3'd1;
    localparam logic [2:0] REG_DRIFT2    = 3'd2;
    localparam logic [2:0] REG_DRIFT3    = 3'd3;
    localparam logic [2:0] REG_SQRT_DT   = 3'd4;
    localparam logic [2:0] REG_NUM_STEPS = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOADW,
        ST_MAC,
        ST_SUM,
        ST_SCALE,
        ST_GROW,
        ST_PLO,
        ST_PHI,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic step_go;
        logic load_w;
        logic mac;
        logic sum;
        logic scale;
        logic grow;
        logic plo;
        logic phi;
        logic upd;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic step_run;
        logic last_asset;
    } status_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        abs32 = a[31] ? 32'(-a) : 32'(a);
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] a);
        abs48 = a[47] ? 48'(-a) : 48'(a);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (a < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = a[31:0];
    endfunction

endpackage

// ===== rtl/core/correlated_gbm_euler_antithetic_core.sv =====
// top level of the correlated euler path core with antithetic passes
// depends on cgbm_pkg, cgbm_ctrl and cgbm_dp (which uses cgbm_ram)
//
// Load and start items are taken and give no result. A step item, while the
// pass has steps left, gives one price per asset. Each asset's price comes from
// a sequence: factor multiply, sum, sqrt_dt scale, drift add, two price partial
// products and update. The price is then offered at the output until it is
// transferred. A step begins with the accept and a sample fetch, then runs
// the sequence for each asset in turn. The block takes no new item until the
// last price of the step is transferred. In a fresh pass the samples go into
// the sample store; if that pass ran all its steps, the next pass reads them
// back negated.
module correlated_gbm_euler_antithetic_core #(
    parameter int NUM_ASSETS = cgbm_pkg::NUM_ASSETS_DEF,
    parameter int MAX_STEPS  = cgbm_pkg::MAX_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cgbm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [1:0]                  row,
    input  logic [1:0]                  col,
    input  logic signed [47:0]          value,
    input  logic signed [31:0]          sample0,
    input  logic signed [31:0]          sample1,
    input  logic signed [31:0]          sample2,
    input  logic signed [31:0]          sample3,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  asset,
    output logic [9:0]                  step_index,
    output logic signed [47:0]          price,
    output logic                        last_of_step
);
    import cgbm_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_accept;

    assign pready    = 1'b1;
    assign in_accept = in_valid && !in_stall;

    cgbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    cgbm_dp #(
        .NUM_ASSETS (NUM_ASSETS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (psel && penable && pwrite && pready),
        .cfg_idx      (paddr[4:2]),
        .cfg_wdata    (pwdata),
        .cfg_rdata    (prdata),
        .in_accept    (in_accept),
        .opcode       (opcode),
        .row          (row),
        .col          (col),
        .value        (value),
        .sample0      (sample0),
        .sample1      (sample1),
        .sample2      (sample2),
        .sample3      (sample3),
        .cmd          (cmd),
        .status       (status),
        .asset        (asset),
        .step_index   (step_index),
        .price        (price),
        .last_of_step (last_of_step)
    );
endmodule

// ===== rtl/core/cgbm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module cgbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/cgbm_ctrl.sv =====
// sequencer for one step item, one asset at a time
// depends on cgbm_pkg
module cgbm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        opcode,
    input  logic              out_stall,
    input  cgbm_pkg::status_t status,
    output cgbm_pkg::cmd_t    cmd,
    output logic              in_stall,
    output logic              out_valid
);
    import cgbm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && opcode == OP_STEP && status.step_run)
                    state_next = ST_LOADW;
            end
            ST_LOADW: state_next = ST_MAC;
            ST_MAC:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_GROW;
            ST_GROW:  state_next = ST_PLO;
            ST_PLO:   state_next = ST_PHI;
            ST_PHI:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = status.last_asset ? ST_IDLE : ST_MAC;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.step_go = in_valid && opcode == OP_STEP && status.step_run;
            end
            ST_LOADW: cmd.load_w = 1'b1;
            ST_MAC:   cmd.mac    = 1'b1;
            ST_SUM:   cmd.sum    = 1'b1;
            ST_SCALE: cmd.scale  = 1'b1;
            ST_GROW:  cmd.grow   = 1'b1;
            ST_PLO:   cmd.plo    = 1'b1;
            ST_PHI:   cmd.phi    = 1'b1;
            ST_UPD:   cmd.upd    = 1'b1;
            ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_done = !out_stall;
            end
            default:  cmd = '0;
        endcase
    end
endmodule

// ===== rtl/core/cgbm_dp.sv =====
// datapath: configuration, factor, prices, sample store and fixed-point arithmetic
// depends on cgbm_pkg and cgbm_ram
module cgbm_dp #(
    parameter int NUM_ASSETS = cgbm_pkg::NUM_ASSETS_DEF,
    parameter int MAX_STEPS  = cgbm_pkg::MAX_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [31:0]         cfg_wdata,
    output logic [31:0]         cfg_rdata,
    input  logic                in_accept,
    input  logic [1:0]          opcode,
    input  logic [1:0]          row,
    input  logic [1:0]          col,
    input  logic signed [47:0]  value,
    input  logic signed [31:0]  sample0,
    input  logic signed [31:0]  sample1,
    input  logic signed [31:0]  sample2,
    input  logic signed [31:0]  sample3,
    input  cgbm_pkg::cmd_t      cmd,
    output cgbm_pkg::status_t   status,
    output logic [1:0]          asset,
    output logic [9:0]          step_index,
    output logic signed [47:0]  price,
    output logic                last_of_step
);
    import cgbm_pkg::*;

    localparam int KW  = NUM_ASSETS > 1 ? $clog2(NUM_ASSETS) : 1;
    localparam int AW  = MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1;
    localparam int CW  = $clog2(MAX_STEPS + 1);
    localparam int RW  = NUM_ASSETS * 32;

    logic signed [31:0] drift_reg [4];
    logic [30:0]        sqrt_dt_reg;
    logic [10:0]        num_steps_reg;
    logic signed [31:0] factor_reg [NUM_ASSETS][NUM_ASSETS];
    logic signed [47:0] spot_reg [NUM_ASSETS];
    logic signed [47:0] cur_reg [NUM_ASSETS];
    logic [CW-1:0]      count_reg;
    logic               anti_reg;
    logic               valid_reg;
    logic [KW-1:0]      k_reg;

    logic signed [31:0] samp_reg [NUM_ASSETS];
    logic signed [31:0] w_reg [NUM_ASSETS];
    logic [63:0]        mac_reg [NUM_ASSETS];
    logic               macneg_reg [NUM_ASSETS];
    logic signed [31:0] corr_reg;
    logic [62:0]        scl_reg;
    logic               sclneg_reg;
    logic signed [31:0] growth_reg;
    logic [55:0]        plo_reg;
    logic [55:0]        phi_reg;

    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      n_wr;
    logic [RW-1:0]      ram_wdata;
    logic [RW-1:0]      ram_rdata;
    logic signed [31:0] in_samp [4];
    logic signed [38:0] corr_sum;
    logic signed [35:0] shock_s;
    logic signed [31:0] shock;
    logic signed [47:0] p_cur;
    logic [47:0]        p_mag;
    logic [31:0]        g_mag;
    logic [80:0]        prod_full;
    logic [52:0]        prod_q;
    logic signed [54:0] p_sum;
    logic signed [47:0] p_new;
    logic               last;

    function automatic logic [CW-1:0] steps_eff(input logic [10:0] ns);
        if (ns == 11'd0)
            steps_eff = CW'(1);
        else if (32'(ns) > MAX_STEPS)
            steps_eff = CW'(MAX_STEPS);
        else
            steps_eff = CW'(ns);
    endfunction

    assign n_eff = steps_eff(num_steps_reg);
    assign n_wr  = steps_eff(cfg_wdata[10:0]);
    assign last  = 32'(k_reg) == NUM_ASSETS - 1;

    assign status.step_run   = count_reg < n_eff;
    assign status.last_asset = last;

    assign in_samp[0] = sample0;
    assign in_samp[1] = sample1;
    assign in_samp[2] = sample2;
    assign in_samp[3] = sample3;

    genvar g;
    generate
        for (g = 0; g < NUM_ASSETS; g++)
        begin : g_pack
            assign ram_wdata[g*32 +: 32] = in_samp[g];
        end
    endgenerate

    cgbm_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_STEPS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.step_go && !anti_reg),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.step_go && anti_reg),
        .raddr (count_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // correlated sum of truncated products
    always_comb
    begin
        corr_sum = '0;
        for (int j = 0; j < NUM_ASSETS; j++)
        begin
            if (macneg_reg[j])
                corr_sum = corr_sum - 39'(mac_reg[j][63:28]);
            else
                corr_sum = corr_sum + 39'(mac_reg[j][63:28]);
        end
    end

    assign shock_s = sclneg_reg ? -36'sh0 - $signed(36'(scl_reg[62:28]))
                                : $signed(36'(scl_reg[62:28]));
    assign shock   = sat32(64'(shock_s));

    assign p_cur     = cur_reg[k_reg];
    assign p_mag     = abs48(p_cur);
    assign g_mag     = abs32(growth_reg);
    assign prod_full = {phi_reg, 24'd0} + 81'(plo_reg);
    assign prod_q    = prod_full[80:28];
    assign p_sum     = (p_cur[47] != growth_reg[31]) ? 55'(p_cur) - $signed(55'(prod_q))
                                                     : 55'(p_cur) + $signed(55'(prod_q));
    always_comb
    begin
        if (p_sum > 55'sh0_7FFF_FFFF_FFFF)
            p_new = 48'sh7FFF_FFFF_FFFF;
        else if (p_sum < -55'sh0_8000_0000_0000)
            p_new = 48'sh8000_0000_0000;
        else
            p_new = p_sum[47:0];
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DRIFT0:    cfg_rdata = drift_reg[0];
            REG_DRIFT1:    cfg_rdata = drift_reg[1];
            REG_DRIFT2:    cfg_rdata = drift_reg[2];
            REG_DRIFT3:    cfg_rdata = drift_reg[3];
            REG_SQRT_DT:   cfg_rdata = {1'b0, sqrt_dt_reg};
            REG_NUM_STEPS: cfg_rdata = {21'd0, num_steps_reg};
            default:       cfg_rdata = '0;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                drift_reg[i] <= '0;
            sqrt_dt_reg   <= '0;
            num_steps_reg <= 11'd1;
            for (int r = 0; r < NUM_ASSETS; r++)
            begin
                for (int c = 0; c < NUM_ASSETS; c++)
                    factor_reg[r][c] <= '0;
                spot_reg[r] <= '0;
                cur_reg[r]  <= '0;
            end
            count_reg <= '0;
            anti_reg  <= 1'b0;
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_DRIFT0:  drift_reg[0] <= cfg_wdata;
                    REG_DRIFT1:  drift_reg[1] <= cfg_wdata;
                    REG_DRIFT2:  drift_reg[2] <= cfg_wdata;
                    REG_DRIFT3:  drift_reg[3] <= cfg_wdata;
                    REG_SQRT_DT: sqrt_dt_reg  <= cfg_wdata[30:0];
                    REG_NUM_STEPS:
                    begin
                        num_steps_reg <= cfg_wdata[10:0];
                        valid_reg     <= 1'b0;
                        count_reg     <= n_wr;
                    end
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                case (opcode)
                    OP_LOAD_FACTOR:
                    begin
                        if (32'(row) < NUM_ASSETS && 32'(col) < NUM_ASSETS)
                            factor_reg[row[KW-1:0]][col[KW-1:0]] <= sat32(64'(value));
                    end
                    OP_LOAD_SPOT:
                    begin
                        if (32'(row) < NUM_ASSETS)
                            spot_reg[row[KW-1:0]] <= value;
                    end
                    OP_START:
                    begin
                        for (int r = 0; r < NUM_ASSETS; r++)
                            cur_reg[r] <= spot_reg[r];
                        count_reg <= '0;
                        anti_reg  <= valid_reg && !anti_reg;
                        if (!(valid_reg && !anti_reg))
                            valid_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.upd)
                cur_reg[k_reg] <= p_new;
            if (cmd.out_done)
            begin
                if (last)
                begin
                    k_reg     <= '0;
                    count_reg <= count_reg + CW'(1);
                    if (!anti_reg && count_reg + CW'(1) == n_eff)
                        valid_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + KW'(1);
                end
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.step_go)
        begin
            for (int j = 0; j < NUM_ASSETS; j++)
                samp_reg[j] <= in_samp[j];
        end
        if (cmd.load_w)
        begin
            for (int j = 0; j < NUM_ASSETS; j++)
            begin
                if (!anti_reg)
                    w_reg[j] <= samp_reg[j];
                else if (ram_rdata[j*32 +: 32] == 32'h8000_0000)
                    w_reg[j] <= 32'sh7FFF_FFFF;
                else
                    w_reg[j] <= -$signed(ram_rdata[j*32 +: 32]);
            end
        end
        if (cmd.mac)
        begin
            for (int j = 0; j < NUM_ASSETS; j++)
            begin
                mac_reg[j]    <= 64'(abs32(factor_reg[k_reg][j])) * 64'(abs32(w_reg[j]));
                macneg_reg[j] <= factor_reg[k_reg][j][31] != w_reg[j][31];
            end
        end
        if (cmd.sum)
            corr_reg <= sat32(64'(corr_sum));
        if (cmd.scale)
        begin
            scl_reg    <= 63'(abs32(corr_reg)) * 63'(sqrt_dt_reg);
            sclneg_reg <= corr_reg[31];
        end
        if (cmd.grow)
            growth_reg <= sat32(64'(drift_reg[2'(k_reg)]) + 64'(shock));
        if (cmd.plo)
            plo_reg <= 56'(p_mag[23:0]) * 56'(g_mag);
        if (cmd.phi)
            phi_reg <= 56'(p_mag[47:24]) * 56'(g_mag);
    end

    assign asset        = 2'(k_reg);
    assign step_index   = 10'(count_reg);
    assign price        = p_cur;
    assign last_of_step = last;
endmodule

// ===== rtl/core/cgbm_checker.sv =====
// port-level checks for the correlated path core, bound to the top level
// depends on cgbm_pkg and the defines header
`include "correlated_gbm_euler_antithetic_core_defines.svh"

module cgbm_checker #(
    parameter int NUM_ASSETS = cgbm_pkg::NUM_ASSETS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  asset,
    input logic [47:0] price,
    input logic        last_of_step
);
    // a waiting result holds until transferred
    `CGBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(price))
    // no item is taken while a result waits
    `CGBM_ASSERT_NOW(a_busy_out, out_valid, in_stall)
    // last flag marks the final asset only
    `CGBM_ASSERT_NOW(a_last, out_valid, last_of_step == (32'(asset) == NUM_ASSETS - 1))
endmodule

bind correlated_gbm_euler_antithetic_core cgbm_checker #(
    .NUM_ASSETS (NUM_ASSETS)
) u_cgbm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .asset        (asset),
    .price        (price),
    .last_of_step (last_of_step)
);
